[rtl/zste_pkg.sv]
// shared types, constants and decode functions of the zoomed sprite tile expander
package zste_pkg;

  // character map size in words, a power of two
  localparam int CGRAM_WORDS = 8192;
  localparam int ADDR_W      = $clog2(CGRAM_WORDS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // attribute word fields
  localparam logic [15:0] ATTR_ENABLE = 16'h0080;

  typedef logic [ADDR_W-1:0]   cg_addr_t;
  typedef logic [QUEUE_AW-1:0] qptr_t;
  typedef logic [QUEUE_AW:0]   qcount_t;

  // zoom to pitch-reduction table, in eighths of a pixel
  localparam logic [5:0] ZOOM_TABLE [16] = '{
    6'd0,  6'd7,  6'd14, 6'd20, 6'd25, 6'd30, 6'd34, 6'd38,
    6'd42, 6'd46, 6'd49, 6'd52, 6'd54, 6'd57, 6'd59, 6'd61
  };

  // one decoded sprite, as handed from front to back
  typedef struct packed {
    logic       chip;
    logic [1:0] pri;
    logic [3:0] color;
    logic       fx;
    logic       fy;
    logic [2:0] xsize;
    logic [2:0] ysize;
    logic [4:0] stepx;
    logic [4:0] stepy;
    logic [8:0] x_start;
    logic [8:0] y_start;
    logic [1:0] skip;
    cg_addr_t   addr;
  } desc_t;

  function automatic logic [4:0] zoom_step_f(input logic [3:0] zoom);
    logic [5:0] t;
    t = ZOOM_TABLE[zoom];
    return 5'd16 - {2'b00, t[5:3]};
  endfunction

  // padding words skipped at the end of each tile row
  function automatic logic [1:0] row_skip_f(input logic [2:0] xsize);
    logic [1:0] s;
    case (xsize)
      3'd2:    s = 2'd1;
      3'd4:    s = 2'd3;
      3'd5:    s = 2'd2;
      3'd6:    s = 2'd1;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic [12:0] map_addr_f(input cg_addr_t a);
    logic [16:0] w;
    w = 17'(a);
    return w[12:0];
  endfunction

  // biased nine-bit position back to signed screen coordinate
  function automatic logic [9:0] screen_pos_f(input logic [8:0] v);
    return {1'b0, v} - 10'd16;
  endfunction

endpackage

[rtl/zste_if.sv]
// sprite entry and tile command channel interfaces
interface zste_sprite_if;
  logic        valid;
  logic        ready;
  logic        chip_select;
  logic [1:0]  priority_mask;
  logic [15:0] y_word;
  logic [15:0] x_word;
  logic [15:0] attr_word;
  logic [15:0] map_base;

  modport source(output valid, chip_select, priority_mask, y_word, x_word, attr_word,
                 map_base, input ready);
  modport sink(input valid, chip_select, priority_mask, y_word, x_word, attr_word,
               map_base, output ready);
endinterface

interface zste_tile_if;
  logic              valid;
  logic              ready;
  logic [12:0]       map_address;
  logic [3:0]        tile_color;
  logic              mirror_x;
  logic              mirror_y;
  logic signed [9:0] screen_x;
  logic signed [9:0] screen_y;
  logic [4:0]        step_x;
  logic [4:0]        step_y;
  logic              chip_out;
  logic [1:0]        priority_out;
  logic              last_tile;

  modport source(output valid, map_address, tile_color, mirror_x, mirror_y, screen_x,
                 screen_y, step_x, step_y, chip_out, priority_out, last_tile, input ready);
  modport sink(input valid, map_address, tile_color, mirror_x, mirror_y, screen_x,
               screen_y, step_x, step_y, chip_out, priority_out, last_tile, output ready);
endinterface

[rtl/zoomed_sprite_tile_expander_unit.sv]
// top level of the zoomed sprite tile expander
// usage:
//   sprite channel: one four-word attribute entry per request (y, x and attribute
//   words, character map base, chip and priority passed along)
//   tile channel: one draw command per request, row by row, last_tile on the final one
//   an entry with the enable bit clear is taken and yields no command
// path: an entry taken while the back end is free goes into the queue, then the walk
//   registers, then the output register, before its first command shows on tile
// walk: (xsize+1)*(ysize+1) commands per enabled sprite, 1 to 64, issued by the
//   tile walker one command per cycle while tile.ready does not stall it; the next
//   sprite, if one is queued, is loaded as the previous last command is registered
//   a two-entry queue lets entries be decoded and taken while a walk is running
// reset: synchronous rst empties the queue, stops any walk and drops tile.valid
// stall: while tile.ready is low the command holds, the walk pauses, and the front
//   keeps taking entries until the queue is full
module zoomed_sprite_tile_expander_unit (
  input  logic         clk,
  input  logic         rst,
  zste_sprite_if.sink  sprite,
  zste_tile_if.source  tile
);

  // decoded sprite handed from the front into the queue
  logic             push_valid;
  logic             push_ready;
  zste_pkg::desc_t  push_data;

  // queue head handed to the tile walker
  logic             pop_valid;
  logic             pop_ready;
  zste_pkg::desc_t  pop_data;

  // decode: enable test, zoom lookup, mirrored start positions, row padding
  zste_front u_front (
    .sprite     (sprite),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples decode from the tile walk
  zste_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // tile walk with running position and map address, registered output
  zste_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .tile      (tile)
  );

endmodule

[rtl/zste_front.sv]
// front end: takes sprite entries, drops disabled ones, decodes the rest
module zste_front (
  zste_sprite_if.sink      sprite,
  output logic             push_valid,
  input  logic             push_ready,
  output zste_pkg::desc_t  push_data
);

  logic [4:0] stepx;
  logic [4:0] stepy;
  logic [2:0] xsize;
  logic [2:0] ysize;
  logic       fx;
  logic       fy;
  logic [7:0] x_span;
  logic [7:0] y_span;

  assign sprite.ready = push_ready;
  assign push_valid   = sprite.valid && ((sprite.attr_word & zste_pkg::ATTR_ENABLE) != 16'h0);

  always_comb begin
    stepx  = zste_pkg::zoom_step_f(sprite.x_word[15:12]);
    stepy  = zste_pkg::zoom_step_f(sprite.y_word[15:12]);
    xsize  = sprite.attr_word[10:8];
    ysize  = sprite.attr_word[14:12];
    fx     = sprite.attr_word[11];
    fy     = sprite.attr_word[15];
    // mirrored walks start from the far tile
    x_span = {3'b000, stepx} * {5'b00000, xsize};
    y_span = {3'b000, stepy} * {5'b00000, ysize};

    push_data.chip    = sprite.chip_select;
    push_data.pri     = sprite.priority_mask;
    push_data.color   = sprite.attr_word[3:0];
    push_data.fx      = fx;
    push_data.fy      = fy;
    push_data.xsize   = xsize;
    push_data.ysize   = ysize;
    push_data.stepx   = stepx;
    push_data.stepy   = stepy;
    push_data.x_start = sprite.x_word[8:0] + 9'd16 + (fx ? {1'b0, x_span} : 9'd0);
    push_data.y_start = sprite.y_word[8:0] + 9'd16 + (fy ? {1'b0, y_span} : 9'd0);
    push_data.skip    = zste_pkg::row_skip_f(xsize);
    push_data.addr    = zste_pkg::cg_addr_t'(sprite.map_base);
  end

endmodule

[rtl/zste_queue.sv]
// short queue of decoded sprites between front and back
module zste_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  zste_pkg::desc_t  push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output zste_pkg::desc_t  pop_data
);

  zste_pkg::desc_t  mem [zste_pkg::QUEUE_DEPTH];
  zste_pkg::qptr_t  wr_ptr;
  zste_pkg::qptr_t  rd_ptr;
  zste_pkg::qcount_t count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != zste_pkg::qcount_t'(zste_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/zste_back.sv]
// back end: walks the tiles of one sprite and registers one command a cycle unless the tile channel stalls
module zste_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  zste_pkg::desc_t  pop_data,
  zste_tile_if.source      tile
);

  zste_pkg::desc_t  desc;
  logic             busy;
  logic [2:0]       col;
  logic [2:0]       row;
  logic [8:0]       xacc;
  logic [8:0]       yacc;
  zste_pkg::cg_addr_t addr;
  logic             emit;
  logic             last_col;
  logic             last_row;
  logic             done;
  logic             load;

  assign last_col  = col == desc.xsize;
  assign last_row  = row == desc.ysize;
  assign emit      = busy && (!tile.valid || tile.ready);
  assign done      = emit && last_col && last_row;
  assign load      = pop_valid && (!busy || done);
  assign pop_ready = !busy || done;

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= pop_data;
      col  <= 3'd0;
      row  <= 3'd0;
      xacc <= pop_data.x_start;
      yacc <= pop_data.y_start;
      addr <= pop_data.addr;
    end else if (emit) begin
      if (last_col) begin
        col  <= 3'd0;
        row  <= row + 3'd1;
        xacc <= desc.x_start;
        yacc <= desc.fy ? yacc - {4'b0000, desc.stepy} : yacc + {4'b0000, desc.stepy};
        addr <= addr + zste_pkg::cg_addr_t'(desc.skip) + zste_pkg::cg_addr_t'(1);
      end else begin
        col  <= col + 3'd1;
        xacc <= desc.fx ? xacc - {4'b0000, desc.stepx} : xacc + {4'b0000, desc.stepx};
        addr <= addr + zste_pkg::cg_addr_t'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tile.valid <= 1'b0;
    end else if (emit) begin
      tile.valid <= 1'b1;
    end else if (tile.ready) begin
      tile.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tile.map_address  <= zste_pkg::map_addr_f(addr);
      tile.tile_color   <= desc.color;
      tile.mirror_x     <= desc.fx;
      tile.mirror_y     <= desc.fy;
      tile.screen_x     <= zste_pkg::screen_pos_f(xacc);
      tile.screen_y     <= zste_pkg::screen_pos_f(yacc);
      tile.step_x       <= desc.stepx;
      tile.step_y       <= desc.stepy;
      tile.chip_out     <= desc.chip;
      tile.priority_out <= desc.pri;
      tile.last_tile    <= last_col && last_row;
    end
  end

endmodule

[rtl/zste_checker.sv]
// port-level checks of the zoomed sprite tile expander and their binding
module zste_checker (
  input logic              clk,
  input logic              rst,
  input logic              tile_valid,
  input logic              tile_ready,
  input logic [12:0]       tile_map_address,
  input logic signed [9:0] tile_screen_x,
  input logic signed [9:0] tile_screen_y,
  input logic [4:0]        tile_step_x,
  input logic [4:0]        tile_step_y,
  input logic              tile_last
);

  // a stalled command holds
  assert property (@(posedge clk) disable iff (rst)
    tile_valid && !tile_ready |=> tile_valid && $stable(tile_map_address)
      && $stable(tile_screen_x) && $stable(tile_last))
    else $error("tile command changed while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !tile_valid)
    else $error("tile valid after reset");

  // pitch stays within the zoom table range
  assert property (@(posedge clk) disable iff (rst)
    tile_valid |-> tile_step_x >= 5'd9 && tile_step_x <= 5'd16
      && tile_step_y >= 5'd9 && tile_step_y <= 5'd16)
    else $error("tile pitch out of range");

  // positions stay within the wrapped screen window
  assert property (@(posedge clk) disable iff (rst)
    tile_valid |-> tile_screen_x >= -10'sd16 && tile_screen_x <= 10'sd495
      && tile_screen_y >= -10'sd16 && tile_screen_y <= 10'sd495)
    else $error("tile position out of range");

endmodule

bind zoomed_sprite_tile_expander_unit zste_checker u_zste_checker (
  .clk              (clk),
  .rst              (rst),
  .tile_valid       (tile.valid),
  .tile_ready       (tile.ready),
  .tile_map_address (tile.map_address),
  .tile_screen_x    (tile.screen_x),
  .tile_screen_y    (tile.screen_y),
  .tile_step_x      (tile.step_x),
  .tile_step_y      (tile.step_y),
  .tile_last        (tile.last_tile)
);

[bench/zoomed_sprite_tile_expander_unit_tb.sv]
// self-checking testbench of the zoomed sprite tile expander: directed and random sprites
package zste_tb_pkg;

  // one sprite attribute entry as offered on the sprite channel
  typedef struct packed {
    logic        chip;
    logic [1:0]  pri;
    logic [15:0] y_word;
    logic [15:0] x_word;
    logic [15:0] attr_word;
    logic [15:0] map_base;
  } sprite_entry_t;

  // one tile draw command as seen on the tile channel
  typedef struct packed {
    logic [12:0] map_address;
    logic [3:0]  tile_color;
    logic        mirror_x;
    logic        mirror_y;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic [4:0]  step_x;
    logic [4:0]  step_y;
    logic        chip_out;
    logic [1:0]  priority_out;
    logic        last_tile;
  } tile_cmd_t;

  // pitch reduction per zoom code, in eighths of a pixel
  localparam int PITCH_CUT [16] = '{
    0, 7, 14, 20, 25, 30, 34, 38, 42, 46, 49, 52, 54, 57, 59, 61
  };

  class tile_scoreboard;
    tile_cmd_t   pending_tiles[$];
    int unsigned errors = 0;

    function int pending();
      return pending_tiles.size();
    endfunction

    static function logic [4:0] tile_pitch(logic [3:0] zoom);
      return 5'(16 - PITCH_CUT[zoom] / 8);
    endfunction

    // nine-bit wrap with a 16 pixel bias, back to a signed 10-bit coordinate
    static function logic [9:0] wrap_screen(int unsigned origin, int unsigned pitch,
                                            int unsigned idx);
      int unsigned v;
      v = (origin + pitch * idx + 16) & 'h1ff;
      return 10'(v - 16);
    endfunction

    // expected tile commands of one accepted sprite entry
    function void expand_sprite(sprite_entry_t s);
      tile_cmd_t   t;
      int unsigned addr;
      int unsigned xs;
      int unsigned ys;
      logic [4:0]  px;
      logic [4:0]  py;
      logic [9:0]  sy;
      if ((s.attr_word & zste_pkg::ATTR_ENABLE) == 16'h0000) return;
      xs   = s.attr_word[10:8];
      ys   = s.attr_word[14:12];
      px   = tile_pitch(s.x_word[15:12]);
      py   = tile_pitch(s.y_word[15:12]);
      addr = s.map_base;
      for (int unsigned row = 0; row <= ys; row++) begin
        sy = wrap_screen(s.y_word[8:0], py, s.attr_word[15] ? ys - row : row);
        for (int unsigned col = 0; col <= xs; col++) begin
          t.map_address  = 13'(addr % zste_pkg::CGRAM_WORDS);
          t.tile_color   = s.attr_word[3:0];
          t.mirror_x     = s.attr_word[11];
          t.mirror_y     = s.attr_word[15];
          t.screen_x     = wrap_screen(s.x_word[8:0], px, s.attr_word[11] ? xs - col : col);
          t.screen_y     = sy;
          t.step_x       = px;
          t.step_y       = py;
          t.chip_out     = s.chip;
          t.priority_out = s.pri;
          t.last_tile    = (row == ys) && (col == xs);
          pending_tiles.push_back(t);
          addr++;
        end
        // padding words at the end of each map row
        case (xs)
          2:       addr += 1;
          4:       addr += 3;
          5:       addr += 2;
          6:       addr += 1;
          default: addr += 0;
        endcase
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_tile(tile_cmd_t got);
      tile_cmd_t want;
      if (pending_tiles.size() == 0) begin
        errors++;
        $display("%0t unexpected tile command: expected none, actual map_address %0h",
                 $time, got.map_address);
        return;
      end
      want = pending_tiles.pop_front();
      compare_field("map_address", want.map_address, got.map_address);
      compare_field("tile_color", want.tile_color, got.tile_color);
      compare_field("mirror_x", want.mirror_x, got.mirror_x);
      compare_field("mirror_y", want.mirror_y, got.mirror_y);
      compare_field("screen_x", want.screen_x, got.screen_x);
      compare_field("screen_y", want.screen_y, got.screen_y);
      compare_field("step_x", want.step_x, got.step_x);
      compare_field("step_y", want.step_y, got.step_y);
      compare_field("chip_out", want.chip_out, got.chip_out);
      compare_field("priority_out", want.priority_out, got.priority_out);
      compare_field("last_tile", want.last_tile, got.last_tile);
    endfunction
  endclass

endpackage

module zoomed_sprite_tile_expander_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zste_tb_pkg::*;

  // longest run of cycles with no request on either channel before giving up
  localparam int IDLE_LIMIT  = 1000;
  // random entries to send after the directed ones
  localparam int RANDOM_SPRITES = 302;
  // cycles left after the last expected command, for stray output
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst;

  zste_sprite_if sprite_ch ();
  zste_tile_if   tile_ch ();

  zoomed_sprite_tile_expander_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .sprite (sprite_ch),
    .tile   (tile_ch)
  );

  tile_scoreboard sb;

  // remaining back-to-back requests of a sender burst
  int unsigned burst_left;

  // 10 ns clock, first rising edge at 5 ns
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // sender gap: mostly none or short, a few long, with gap-free bursts now and then
  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sprite_entry_t make_sprite(logic chip, logic [1:0] pri,
                                                logic [15:0] yw, logic [15:0] xw,
                                                logic [15:0] aw, logic [15:0] base);
    sprite_entry_t s;
    s.chip      = chip;
    s.pri       = pri;
    s.y_word    = yw;
    s.x_word    = xw;
    s.attr_word = aw;
    s.map_base  = base;
    return s;
  endfunction

  // random entry: mostly enabled with random content, some disabled noise,
  // some with every bit left to chance
  function automatic sprite_entry_t random_sprite();
    sprite_entry_t s;
    int unsigned   pick;
    s = make_sprite(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    pick = $urandom_range(0, 99);
    if (pick < 10)
      s.attr_word = s.attr_word & ~zste_pkg::ATTR_ENABLE;
    else if (pick >= 20)
      s.attr_word = s.attr_word | zste_pkg::ATTR_ENABLE;
    return s;
  endfunction

  // offer one entry after an optional gap and hold it until the request is taken;
  // called at a rising edge, returns at the edge where the entry was accepted
  task automatic send_sprite(input sprite_entry_t s);
    int unsigned gap;
    gap = sender_gap();
    if (gap != 0) begin
      sprite_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sprite_ch.valid         <= 1'b1;
    sprite_ch.chip_select   <= s.chip;
    sprite_ch.priority_mask <= s.pri;
    sprite_ch.y_word        <= s.y_word;
    sprite_ch.x_word        <= s.x_word;
    sprite_ch.attr_word     <= s.attr_word;
    sprite_ch.map_base      <= s.map_base;
    @(posedge clk);
    while (!sprite_ch.ready) @(posedge clk);
    sb.expand_sprite(s);
  endtask

  // drop valid and wait for every expected tile command to come out
  task automatic hold_until_drained();
    sprite_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin : sprite_source
    int unsigned   random_sent;
    int unsigned   xs;
    sprite_entry_t s;
    sb         = new;
    burst_left = 0;
    rst                     <= 1'b1;
    sprite_ch.valid         <= 1'b0;
    sprite_ch.chip_select   <= 1'b0;
    sprite_ch.priority_mask <= 2'd0;
    sprite_ch.y_word        <= 16'h0000;
    sprite_ch.x_word        <= 16'h0000;
    sprite_ch.attr_word     <= 16'h0000;
    sprite_ch.map_base      <= 16'h0000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // disabled entries: all clear, and every other bit set
    send_sprite(make_sprite(1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_sprite(make_sprite(1'b1, 2'd3, 16'hffff, 16'hffff, 16'hff7f, 16'hffff));
    // single tile at the origin, no zoom
    send_sprite(make_sprite(1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0080, 16'h0000));
    // everything set: 8x8, both flips, strongest zoom, position 0x1ff, address wrap
    send_sprite(make_sprite(1'b1, 2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    // every width, so every row padding case, two rows each, zoom swept both ways
    for (xs = 0; xs < 8; xs++) begin
      send_sprite(make_sprite(xs[0], 2'(xs % 3),
                              {4'(15 - 2 * xs), 3'd0, 9'(xs * 61)},
                              {4'(2 * xs), 3'd0, 9'(xs * 37 + 400)},
                              16'h1080 | 16'(xs << 8) | 16'(xs),
                              16'h1ff0 + 16'(xs * 3)));
    end
    // flip combinations on a 3x3 sprite near the right edge
    for (int f = 0; f < 4; f++) begin
      send_sprite(make_sprite(f[0], 2'(f), 16'h5005, 16'ha1f8,
                              16'h2289 | (f[0] ? 16'h0800 : 16'h0000)
                                       | (f[1] ? 16'h8000 : 16'h0000),
                              16'h0100));
    end
    // large sprite wrapping around the screen and the map size boundary
    send_sprite(make_sprite(1'b0, 2'd2, 16'hf1f0, 16'h01f0, 16'h7780, 16'h1fff));
    // one row of four, no padding, base zero
    send_sprite(make_sprite(1'b1, 2'd1, 16'h8100, 16'h7001, 16'h0380, 16'h0000));

    // drain: sender waits for all output before going random
    hold_until_drained();

    random_sent = 0;
    while (random_sent < RANDOM_SPRITES) begin
      s = random_sprite();
      send_sprite(s);
      random_sent++;
      // pause the sender now and then until every expected command has come out
      if (random_sent % 100 == 50) hold_until_drained();
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: check every accepted command, stall ready at random
  initial begin : tile_sink
    tile_cmd_t   got;
    int unsigned stall_left;
    int unsigned quiet_left;
    int unsigned pick;
    stall_left = 0;
    quiet_left = 0;
    tile_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && tile_ch.valid && tile_ch.ready) begin
        got.map_address  = tile_ch.map_address;
        got.tile_color   = tile_ch.tile_color;
        got.mirror_x     = tile_ch.mirror_x;
        got.mirror_y     = tile_ch.mirror_y;
        got.screen_x     = tile_ch.screen_x;
        got.screen_y     = tile_ch.screen_y;
        got.step_x       = tile_ch.step_x;
        got.step_y       = tile_ch.step_y;
        got.chip_out     = tile_ch.chip_out;
        got.priority_out = tile_ch.priority_out;
        got.last_tile    = tile_ch.last_tile;
        sb.check_tile(got);
      end
      if (stall_left != 0) begin
        tile_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        tile_ch.ready <= 1'b1;
        if (quiet_left != 0) begin
          // stretch with ready held high
          quiet_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 3)
            quiet_left = $urandom_range(40, 150);
          else if (pick < 8)
            stall_left = $urandom_range(10, 40);
          else if (pick < 30)
            stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  // watchdog: too long without a request on either channel ends the run
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sprite_ch.valid && sprite_ch.ready) || (tile_ch.valid && tile_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t watchdog: no request for %0d cycles", $time, IDLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
